/* design/bounded_double_ended_queue_assert.svh */
// Assertion macros shared by the queue modules.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define BDQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("queue assertion failed");
// Checked at every edge, reset included.
`define BDQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("queue assertion failed");
`else
`define BDQ_ASSERT(lbl, clk, rst_n, prop)
`define BDQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* design/bdq_pkg.sv */
package bdq_pkg;

  localparam int DEF_CAPACITY  = 128;
  localparam int DEF_WORD_BITS = 16;

  localparam int CMD_W = 3;
  localparam int ST_W  = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STATUS     = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // Sequencer strobes to the datapath, at most one per cycle.
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // update pointers and write the store
    logic rd;    // read both end words
    logic resp;  // load the result register
  } bdq_cmd_t;

endpackage

/* design/bdq_in_if.sv */
interface bdq_in_if import bdq_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [WORD_BITS-1:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink (input valid, input command, input push_value, output ready);
endinterface

/* design/bdq_out_if.sv */
interface bdq_out_if import bdq_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS,
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) ();
  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      status;
  logic [WORD_BITS-1:0] popped_value;
  logic [WORD_BITS-1:0] front_value;
  logic [WORD_BITS-1:0] back_value;
  logic [CNT_W-1:0]     occupancy;
  logic                 is_empty;
  logic                 is_full;

  modport source (
    output valid, output status, output popped_value, output front_value,
    output back_value, output occupancy, output is_empty, output is_full,
    input ready
  );
  modport sink (
    input valid, input status, input popped_value, input front_value,
    input back_value, input occupancy, input is_empty, input is_full,
    output ready
  );
endinterface

/* design/bdq_ctrl.sv */
`include "bounded_double_ended_queue_assert.svh"

module bdq_ctrl import bdq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output bdq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // hold until the result register is free or being emptied
        if (!out_valid_r || out_ready) begin
          cmd.resp  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.resp) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `BDQ_ASSERT(a_one_strobe, clk, rst_n, $onehot0({cmd.load, cmd.exec, cmd.rd, cmd.resp}))
  `BDQ_ASSERT(a_accept_exec, clk, rst_n, (in_valid && in_ready) |=> (state_r == S_EXEC))
  `BDQ_ASSERT(a_resp_free, clk, rst_n, cmd.resp |-> (!out_valid_r || out_ready))

endmodule

/* design/bdq_datapath.sv */
`include "bounded_double_ended_queue_assert.svh"

module bdq_datapath import bdq_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS,
  localparam int IDX_W    = $clog2(CAPACITY),
  localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bdq_cmd_t             cmd,
  input  logic [CMD_W-1:0]     in_command,
  input  logic [WORD_BITS-1:0] in_push_value,
  output logic [ST_W-1:0]      out_status,
  output logic [WORD_BITS-1:0] out_popped_value,
  output logic [WORD_BITS-1:0] out_front_value,
  output logic [WORD_BITS-1:0] out_back_value,
  output logic [CNT_W-1:0]     out_occupancy,
  output logic                 out_is_empty,
  output logic                 out_is_full
);

  localparam int SUM_W = CNT_W + 1;

  logic [WORD_BITS-1:0] mem [CAPACITY];

  logic [CMD_W-1:0]     cmd_r;
  logic [WORD_BITS-1:0] word_r;
  logic [IDX_W-1:0]     head_r;
  logic [IDX_W-1:0]     head_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic [WORD_BITS-1:0] front_rd_r;
  logic [WORD_BITS-1:0] back_rd_r;
  logic [ST_W-1:0]      status_r;
  logic [ST_W-1:0]      status_nxt;
  logic [WORD_BITS-1:0] popped_r;
  logic [WORD_BITS-1:0] popped_nxt;

  logic [ST_W-1:0]      out_status_r;
  logic [WORD_BITS-1:0] out_popped_r;
  logic [WORD_BITS-1:0] out_front_r;
  logic [WORD_BITS-1:0] out_back_r;
  logic [CNT_W-1:0]     out_occupancy_r;
  logic                 out_is_empty_r;
  logic                 out_is_full_r;

  logic                 is_full;
  logic                 is_empty;
  logic [IDX_W-1:0]     head_dec;
  logic [IDX_W-1:0]     head_inc;
  logic [SUM_W-1:0]     tail_sum;
  logic [IDX_W-1:0]     tail_addr;
  logic [SUM_W-1:0]     back_sum;
  logic [IDX_W-1:0]     back_addr;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;

  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  assign head_dec = (head_r == '0) ? IDX_W'(CAPACITY - 1) : head_r - 1'b1;
  assign head_inc = (head_r == IDX_W'(CAPACITY - 1)) ? '0 : head_r + 1'b1;

  // First free slot behind the back word, wrapped once
  assign tail_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_addr = (tail_sum >= SUM_W'(CAPACITY)) ?
                     IDX_W'(tail_sum - SUM_W'(CAPACITY)) : IDX_W'(tail_sum);

  // Back word position; falls back to the head when empty
  assign back_sum  = is_empty ? SUM_W'(head_r) : tail_sum - 1'b1;
  assign back_addr = (back_sum >= SUM_W'(CAPACITY)) ?
                     IDX_W'(back_sum - SUM_W'(CAPACITY)) : IDX_W'(back_sum);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    popped_nxt = '0;
    mem_we     = 1'b0;
    mem_waddr  = tail_addr;
    case (cmd_r) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          if (cmd_r == CMD_PUSH_FRONT) begin
            head_nxt  = head_dec;
            mem_waddr = head_dec;
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
          if (cmd_r == CMD_POP_FRONT) begin
            popped_nxt = front_rd_r;
            head_nxt   = head_inc;
          end else begin
            popped_nxt = back_rd_r;
          end
        end
      end
      default: ;
    endcase
    if (!cmd.exec) begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      word_r <= in_push_value;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      popped_r <= popped_nxt;
    end
  end

  // Store: one write port, two registered read ports for the end words
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= word_r;
    end
    if (cmd.rd) begin
      front_rd_r <= mem[head_r];
      back_rd_r  <= mem[back_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_status_r    <= status_r;
      out_popped_r    <= popped_r;
      out_front_r     <= is_empty ? '0 : front_rd_r;
      out_back_r      <= is_empty ? '0 : back_rd_r;
      out_occupancy_r <= count_r;
      out_is_empty_r  <= is_empty;
      out_is_full_r   <= is_full;
    end
  end

  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;
  assign out_front_value  = out_front_r;
  assign out_back_value   = out_back_r;
  assign out_occupancy    = out_occupancy_r;
  assign out_is_empty     = out_is_empty_r;
  assign out_is_full      = out_is_full_r;

  `BDQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CNT_W'(CAPACITY))
  `BDQ_ASSERT(a_head_bound, clk, rst_n, head_r <= IDX_W'(CAPACITY - 1))
  `BDQ_ASSERT(a_no_write_full, clk, rst_n, mem_we |-> (!is_full && cmd.exec))

endmodule

/* design/bounded_double_ended_queue.sv */
// Bounded double-ended queue of WORD_BITS-bit words, up to CAPACITY deep.
// Input channel in_if carries one command per item: push front, push back,
// pop front, pop back or status only (unused codes act as status only), with
// push_value used by the pushes. Output channel out_if returns exactly one
// result per command: status (done, refused full, refused empty), the popped
// word, the front and back words and the occupancy after the step, plus the
// empty and full flags. End words read as zero while the queue is empty.
// Steps: the sequencer captures the item, writes the store and moves the
// pointers, reads both ends through the registered read ports, then loads
// the result register. in_ready is high only while the sequencer is idle,
// so a new item is not taken until the last one has loaded its result.
// Reset (synchronous, active low) empties the queue; stored words are not
// cleared and no clearing pass runs. A stalled receiver holds the result
// register; the next item is still taken and executed, and waits for the
// result register to free before its result is loaded.
module bounded_double_ended_queue import bdq_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input logic              clk,
  input logic              rst_n,
  bdq_in_if.sink           in_if,
  bdq_out_if.source        out_if
);

  bdq_cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  bdq_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_command       (in_if.command),
    .in_push_value    (in_if.push_value),
    .out_status       (out_if.status),
    .out_popped_value (out_if.popped_value),
    .out_front_value  (out_if.front_value),
    .out_back_value   (out_if.back_value),
    .out_occupancy    (out_if.occupancy),
    .out_is_empty     (out_if.is_empty),
    .out_is_full      (out_if.is_full)
  );

endmodule

/* sim/bounded_double_ended_queue_test.sv */
`timescale 1ns / 1ps

module bounded_double_ended_queue_test;
  import bdq_pkg::*;

  localparam int CAP   = DEF_CAPACITY;
  localparam int WB    = DEF_WORD_BITS;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int TOTAL_CMDS = 1450;

  // Codes outside the defined set; the block treats them as status only.
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [WB-1:0]    word;
  } deque_request_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [WB-1:0]    popped;
    logic [WB-1:0]    front;
    logic [WB-1:0]    back;
    logic [CNT_W-1:0] occupancy;
    logic             is_empty;
    logic             is_full;
  } deque_result_t;

  logic clk;
  logic rst_n;

  bdq_in_if  #(.WORD_BITS(WB))                  in_ch ();
  bdq_out_if #(.CAPACITY(CAP), .WORD_BITS(WB)) out_ch ();

  bounded_double_ended_queue #(.CAPACITY(CAP), .WORD_BITS(WB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Shadow copy of the deque contents.
  logic [WB-1:0] shadow_words [CAP];
  int            shadow_head;
  int            shadow_count;

  deque_request_t pending_commands [$];
  deque_result_t  awaited_results [$];

  int total_queued;
  int cmds_accepted;
  int results_checked;
  int mismatch_count;
  int full_refusals;
  int empty_refusals;
  int peak_occupancy;

  int burst_left;
  int gap_left;
  int stall_left;
  int stall_phase;
  logic [6:0] stall_mask;

  function automatic deque_result_t deque_step(input logic [CMD_W-1:0] cmd,
                                               input logic [WB-1:0] word);
    deque_result_t r;
    r = '0;
    r.status = ST_DONE;
    if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) begin
      if (shadow_count == CAP) begin
        r.status = ST_FULL;
        full_refusals++;
      end else if (cmd == CMD_PUSH_FRONT) begin
        shadow_head = (shadow_head + CAP - 1) % CAP;
        shadow_words[shadow_head] = word;
        shadow_count++;
      end else begin
        shadow_words[(shadow_head + shadow_count) % CAP] = word;
        shadow_count++;
      end
    end else if (cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
        empty_refusals++;
      end else if (cmd == CMD_POP_FRONT) begin
        r.popped = shadow_words[shadow_head];
        shadow_head = (shadow_head + 1) % CAP;
        shadow_count--;
      end else begin
        r.popped = shadow_words[(shadow_head + shadow_count - 1) % CAP];
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      r.front = shadow_words[shadow_head];
      r.back  = shadow_words[(shadow_head + shadow_count - 1) % CAP];
    end
    r.occupancy = shadow_count[CNT_W-1:0];
    r.is_empty  = (shadow_count == 0);
    r.is_full   = (shadow_count == CAP);
    if (shadow_count > peak_occupancy) peak_occupancy = shadow_count;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic queue_command(input logic [CMD_W-1:0] cmd, input logic [WB-1:0] word);
    deque_request_t req;
    req.command = cmd;
    req.word    = word;
    pending_commands.push_back(req);
    total_queued++;
  endtask

  function automatic logic [WB-1:0] pick_word();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: return '0;
      1: return '1;
      2: return WB'(1) << $urandom_range(0, WB - 1);
      default: return WB'($urandom_range(0, (1 << WB) - 1));
    endcase
  endfunction

  // Status only or one of the unused codes.
  function automatic logic [CMD_W-1:0] pick_spare_command();
    return CMD_W'($urandom_range(CMD_STATUS, CMD_SPARE_C));
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(input traffic_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 45) return CMD_PUSH_FRONT;
        if (roll < 90) return CMD_PUSH_BACK;
        if (roll < 93) return CMD_POP_FRONT;
        if (roll < 96) return CMD_POP_BACK;
        return pick_spare_command();
      end
      MIX_DRAIN: begin
        if (roll < 45) return CMD_POP_FRONT;
        if (roll < 90) return CMD_POP_BACK;
        if (roll < 93) return CMD_PUSH_FRONT;
        if (roll < 96) return CMD_PUSH_BACK;
        return pick_spare_command();
      end
      default: return CMD_W'($urandom_range(CMD_PUSH_FRONT, CMD_SPARE_C));
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("bounded_double_ended_queue_test: FAIL");
    $finish;
  end

  initial begin : stimulus_proc
    traffic_mix_t mix;
    int seg_len;
    int phase;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_STATUS;
    in_ch.push_value = '0;
    out_ch.ready     = 1'b0;
    shadow_head      = 0;
    shadow_count     = 0;
    total_queued     = 0;
    cmds_accepted    = 0;
    results_checked  = 0;
    mismatch_count   = 0;
    full_refusals    = 0;
    empty_refusals   = 0;
    peak_occupancy   = 0;
    burst_left       = 1;
    gap_left         = 0;
    stall_left       = 0;
    stall_phase      = 0;
    stall_mask       = '1;

    // Directed: refusals on empty, unused codes, both ends, single word.
    queue_command(CMD_STATUS, '0);
    queue_command(CMD_POP_FRONT, '0);
    queue_command(CMD_POP_BACK, '1);
    queue_command(CMD_SPARE_A, '1);
    queue_command(CMD_SPARE_B, '0);
    queue_command(CMD_SPARE_C, 16'h5A5A);
    queue_command(CMD_PUSH_BACK, '1);
    queue_command(CMD_PUSH_FRONT, '0);
    queue_command(CMD_PUSH_FRONT, 16'hA5A5);
    queue_command(CMD_PUSH_BACK, 16'h8001);
    queue_command(CMD_STATUS, 16'h1234);
    queue_command(CMD_POP_BACK, '0);
    queue_command(CMD_POP_FRONT, '0);
    queue_command(CMD_POP_FRONT, '0);
    queue_command(CMD_POP_BACK, '0);
    queue_command(CMD_POP_FRONT, '0);
    queue_command(CMD_PUSH_FRONT, 16'h0001);
    queue_command(CMD_POP_BACK, '0);
    queue_command(CMD_PUSH_BACK, 16'h7FFE);
    queue_command(CMD_POP_FRONT, '0);
    queue_command(CMD_POP_BACK, '0);

    // Random: rotate fill, mixed and drain stretches so both full and empty recur.
    phase = 0;
    while (total_queued < TOTAL_CMDS) begin
      case (phase % 4)
        0: mix = MIX_FILL;
        2: mix = MIX_DRAIN;
        default: mix = MIX_BALANCED;
      endcase
      seg_len = (mix == MIX_BALANCED) ? $urandom_range(40, 120) : $urandom_range(180, 300);
      // Trim the last stretch to the planned item count
      if (seg_len > TOTAL_CMDS - total_queued) seg_len = TOTAL_CMDS - total_queued;
      repeat (seg_len) queue_command(pick_command(mix), pick_word());
      phase++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (cmds_accepted == total_queued);
    wait (awaited_results.size() == 0);
    repeat (16) @(posedge clk);

    $display("covered %0d commands and %0d checked results, peak occupancy %0d",
             cmds_accepted, results_checked, peak_occupancy);
    $display("pushes refused while full: %0d, pops refused while empty: %0d",
             full_refusals, empty_refusals);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("bounded_double_ended_queue_test: PASS");
    end else begin
      $display("bounded_double_ended_queue_test: FAIL");
    end
    $finish;
  end

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin : drive_proc
    deque_request_t req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        awaited_results.push_back(deque_step(in_ch.command, in_ch.push_value));
        cmds_accepted++;
      end
      if (gap_left > 0 || pending_commands.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        req = pending_commands.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.command    <= req.command;
        in_ch.push_value <= req.word;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 11);
        end
      end
    end
  end

  // Receiver: stall on a rotating 7-bit mask, re-chosen every stretch.
  always @(posedge clk) begin : receive_proc
    deque_result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("result arrived with none outstanding");
        end else begin
          exp_r = awaited_results.pop_front();
          if (out_ch.status !== exp_r.status)
            flag_mismatch($sformatf("result %0d status %0d, want %0d",
                                    results_checked, out_ch.status, exp_r.status));
          if (out_ch.popped_value !== exp_r.popped)
            flag_mismatch($sformatf("result %0d popped %h, want %h",
                                    results_checked, out_ch.popped_value, exp_r.popped));
          if (out_ch.front_value !== exp_r.front)
            flag_mismatch($sformatf("result %0d front %h, want %h",
                                    results_checked, out_ch.front_value, exp_r.front));
          if (out_ch.back_value !== exp_r.back)
            flag_mismatch($sformatf("result %0d back %h, want %h",
                                    results_checked, out_ch.back_value, exp_r.back));
          if (out_ch.occupancy !== exp_r.occupancy)
            flag_mismatch($sformatf("result %0d occupancy %0d, want %0d",
                                    results_checked, out_ch.occupancy, exp_r.occupancy));
          if (out_ch.is_empty !== exp_r.is_empty)
            flag_mismatch($sformatf("result %0d empty flag %b, want %b",
                                    results_checked, out_ch.is_empty, exp_r.is_empty));
          if (out_ch.is_full !== exp_r.is_full)
            flag_mismatch($sformatf("result %0d full flag %b, want %b",
                                    results_checked, out_ch.is_full, exp_r.is_full));
          results_checked++;
        end
      end
      if (stall_left == 0) begin
        stall_mask = ($urandom_range(0, 2) == 0) ? 7'h7F : 7'($urandom_range(1, 127));
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      out_ch.ready <= stall_mask[stall_phase];
      stall_phase = (stall_phase == 6) ? 0 : stall_phase + 1;
    end
  end

endmodule

/* bounded_double_ended_queue.f */
+incdir+design
design/bdq_pkg.sv
design/bdq_in_if.sv
design/bdq_out_if.sv
design/bdq_ctrl.sv
design/bdq_datapath.sv
design/bounded_double_ended_queue.sv
sim/bounded_double_ended_queue_test.sv
